// File: design/aht_pkg.sv
package aht_pkg;

  // Knob clamp limits in whole degrees, and the last second of a minute.
  localparam logic [7:0] KNOB_LOW       = 8'd10;
  localparam logic [7:0] KNOB_HIGH      = 8'd65;
  localparam logic [6:0] SEC_LAST       = 7'd59;
  localparam logic [7:0] MAX_WAIT_RESET = 8'd103;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SET_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_BELOW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_ABOVE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_WAIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HEAT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_WAIT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WAIT   = 3'd6;

  typedef struct packed {
    logic signed [5:0] set_offset;
    logic [7:0]        band_below;
    logic [7:0]        band_above;
    logic [5:0]        min_wait;
    logic [5:0]        min_heat;
    logic [7:0]        idle_wait;
    logic [7:0]        max_wait;
  } aht_cfg_t;

  typedef struct packed {
    logic              op;
    logic              standby_on;
    logic              heat_enable;
    logic              adc_ready;
    logic              heat_lock;
    logic              error_mode;
    logic [7:0]        knob_value;
    logic signed [11:0] temperature;
    logic              second_tick;
    logic              fan_release;
  } aht_item_t;

  typedef struct packed {
    logic       demand;
    logic       fall_wait;
    logic [7:0] wait_limit;
    logic [7:0] off_minutes;
    logic [5:0] second_count;
    logic       second_pending;
    logic       fan_hold;
    logic       heater_pin;
    logic       fan_pin;
  } aht_state_t;

  typedef struct packed {
    logic       heater_on;
    logic       fan_on;
    logic       fan_hold;
    logic [7:0] wait_limit_now;
  } aht_result_t;

  function automatic logic [7:0] sat_add8(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

  function automatic logic [7:0] sat_sub8(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : 8'd0;
  endfunction

endpackage

// File: design/aht_core.sv
module aht_core (
  input  aht_pkg::aht_cfg_t   cfg,
  input  aht_pkg::aht_state_t cur,
  input  aht_pkg::aht_item_t  item,
  output aht_pkg::aht_state_t nxt
);
  import aht_pkg::*;

  logic [7:0]        base;
  logic [7:0]        min_wait8;
  logic [7:0]        min_heat8;
  logic [7:0]        knob;
  logic signed [7:0] set_deg;
  logic signed [13:0] set16;
  logic signed [13:0] temp14;
  logic signed [13:0] on_lvl;
  logic signed [13:0] off_lvl;
  logic [7:0]        tf;
  logic [6:0]        sec_inc;
  logic              skip_count;

  // Heater and fan pins follow demand; the fan stays on while held.
  function automatic aht_state_t drive_pins(input aht_state_t s);
    aht_state_t r;
    r = s;
    if (s.demand) begin
      r.heater_pin = 1'b1;
      r.fan_pin    = 1'b1;
      r.fan_hold   = 1'b1;
    end else begin
      r.heater_pin = 1'b0;
      if (!s.fan_hold) r.fan_pin = 1'b0;
    end
    return r;
  endfunction

  assign min_wait8 = {2'b00, cfg.min_wait};
  assign min_heat8 = {2'b00, cfg.min_heat};
  assign base      = sat_add8(min_wait8, min_heat8);

  always_comb begin
    knob = item.knob_value;
    if (knob < KNOB_LOW) knob = KNOB_LOW;
    if (knob > KNOB_HIGH) knob = KNOB_HIGH;
  end

  assign set_deg = signed'(knob) + {{2{cfg.set_offset[5]}}, cfg.set_offset};
  assign set16   = {{2{set_deg[7]}}, set_deg, 4'b0000};
  assign temp14  = {{2{item.temperature[11]}}, item.temperature};
  assign on_lvl  = temp14 + signed'({6'd0, cfg.band_below});
  assign off_lvl = temp14 - signed'({6'd0, cfg.band_above});

  always_comb begin
    nxt        = cur;
    tf         = 8'd0;
    sec_inc    = 7'd0;
    skip_count = 1'b0;

    if (item.fan_release) nxt.fan_hold = 1'b0;
    if (item.second_tick) nxt.second_pending = 1'b1;

    if (item.op) begin
      // Start item: force a boost run with the shortest wait.
      nxt.demand       = 1'b1;
      nxt.fall_wait    = 1'b1;
      nxt.wait_limit   = min_wait8;
      nxt.off_minutes  = sat_sub8(min_wait8, min_heat8);
      nxt.second_count = 6'd0;
    end else if (!item.standby_on || !item.heat_enable || !item.adc_ready ||
                 item.heat_lock) begin
      nxt.heater_pin = 1'b0;
      nxt.demand     = 1'b0;
      if (!nxt.fan_hold) nxt.fan_pin = 1'b0;
    end else if (item.error_mode) begin
      nxt.demand = 1'b1;
      nxt        = drive_pins(nxt);
    end else if (set16 >= on_lvl) begin
      // Below the switch-on level: heat, and shorten the wait on a re-heat.
      if (!nxt.demand) begin
        nxt.demand     = 1'b1;
        nxt.wait_limit = base;
      end
      if (nxt.fall_wait) begin
        nxt.fall_wait = 1'b0;
        tf = sat_add8(nxt.off_minutes, min_heat8);
        if (tf >= nxt.wait_limit) begin
          tf = sat_sub8(nxt.wait_limit, min_heat8);
          if (tf <= base) tf = base;
          nxt.wait_limit = tf;
        end
      end
      nxt.off_minutes  = 8'd0;
      nxt.second_count = 6'd0;
      nxt = drive_pins(nxt);
    end else begin
      if (set16 <= off_lvl) begin
        if (nxt.demand && !nxt.fall_wait) begin
          nxt.demand = 1'b0;
          if (nxt.wait_limit <= min_wait8) nxt.wait_limit = base;
        end
      end else if (nxt.demand) begin
        if (!nxt.fall_wait) skip_count = 1'b1;
      end else begin
        nxt.wait_limit = cfg.idle_wait;
      end

      if (!skip_count) begin
        if (!nxt.demand && nxt.fan_hold) begin
          nxt.second_count = 6'd0;
          nxt.off_minutes  = 8'd0;
        end else if (nxt.second_pending) begin
          nxt.second_pending = 1'b0;
          sec_inc = {1'b0, nxt.second_count} + 7'd1;
          if (sec_inc > SEC_LAST) begin
            nxt.second_count = 6'd0;
            nxt.off_minutes  = sat_add8(nxt.off_minutes, 8'd1);
          end else begin
            nxt.second_count = sec_inc[5:0];
          end
        end

        tf = sat_add8(nxt.off_minutes, min_heat8);
        if (tf >= nxt.wait_limit) begin
          nxt.fall_wait = 1'b1;
          nxt.demand    = 1'b1;
          if (nxt.off_minutes >= nxt.wait_limit) begin
            // The whole wait passed without a re-heat: lengthen it.
            tf = sat_add8(nxt.wait_limit, min_heat8);
            if (tf >= cfg.max_wait) tf = cfg.max_wait;
            nxt.wait_limit   = tf;
            nxt.demand       = 1'b0;
            nxt.fall_wait    = 1'b0;
            nxt.off_minutes  = 8'd0;
            nxt.second_count = 6'd0;
          end
        end
      end
      nxt = drive_pins(nxt);
    end
  end

endmodule

// File: design/adaptive_heater_thermostat.sv
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+--------------------------------------
// in_      | slave     | in_tvalid/tready   | in_tdata[26:0] fields, in_tuser = op
// out_     | master    | out_tvalid/tready  | out_tdata[10:0] result fields
// cfg_     | write     | cfg_we             | cfg_index[2:0], cfg_wdata[7:0]
//
// Each accepted beat runs through one compare-and-select pass and updates the state at
// that edge; its result is registered into the output register at that same edge, or
// into the skid register while it stalls; one beat per cycle unless out_tready is low.
// in_tready drops only while the skid register is full, so both entries wait on out_.
// rst_n is synchronous and active low; it clears the state, the buffer and the
// configuration registers to their defaults.
module adaptive_heater_thermostat (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [0] standby_on, [1] heat_enable, [2] adc_ready, [3] heat_lock, [4] error_mode,
  // [12:5] knob_value, [24:13] temperature, [25] second_tick, [26] fan_release
  input  logic [31:0] in_tdata,
  // [0] op (0 control step, 1 start boost)
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] heater_on, [1] fan_on, [2] fan_hold, [10:3] wait_limit_now
  output logic [15:0] out_tdata,
  input  logic        cfg_we,
  input  logic [aht_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [aht_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import aht_pkg::*;

  aht_cfg_t    cfg_r;
  aht_state_t  st_r;
  aht_state_t  st_nxt;
  aht_item_t   item;
  aht_result_t res;
  aht_result_t out_r;
  aht_result_t skid_r;
  logic        out_valid_r;
  logic        skid_valid_r;
  logic        in_fire;
  logic        out_free;

  // Unpack the input beat into the item fields.
  assign item.op          = in_tuser;
  assign item.standby_on  = in_tdata[0];
  assign item.heat_enable = in_tdata[1];
  assign item.adc_ready   = in_tdata[2];
  assign item.heat_lock   = in_tdata[3];
  assign item.error_mode  = in_tdata[4];
  assign item.knob_value  = in_tdata[12:5];
  assign item.temperature = in_tdata[24:13];
  assign item.second_tick = in_tdata[25];
  assign item.fan_release = in_tdata[26];

  aht_core u_core (
    .cfg  (cfg_r),
    .cur  (st_r),
    .item (item),
    .nxt  (st_nxt)
  );

  // The result of a beat is the state right after it.
  assign res.heater_on      = st_nxt.heater_pin;
  assign res.fan_on         = st_nxt.fan_pin;
  assign res.fan_hold       = st_nxt.fan_hold;
  assign res.wait_limit_now = st_nxt.wait_limit;

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  // The result register can take a new entry when empty or being drained.
  assign out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_r.wait_limit_now, out_r.fan_hold, out_r.fan_on,
                       out_r.heater_on};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.set_offset <= 6'sd0;
      cfg_r.band_below <= 8'd16;
      cfg_r.band_above <= 8'd16;
      cfg_r.min_wait   <= 6'd3;
      cfg_r.min_heat   <= 6'd3;
      cfg_r.idle_wait  <= 8'd15;
      cfg_r.max_wait   <= MAX_WAIT_RESET;
      st_r.demand         <= 1'b0;
      st_r.fall_wait      <= 1'b0;
      st_r.wait_limit     <= 8'd6;
      st_r.off_minutes    <= 8'd0;
      st_r.second_count   <= 6'd0;
      st_r.second_pending <= 1'b0;
      st_r.fan_hold       <= 1'b0;
      st_r.heater_pin     <= 1'b0;
      st_r.fan_pin        <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SET_OFFSET: cfg_r.set_offset <= cfg_wdata[5:0];
          CFG_BAND_BELOW: cfg_r.band_below <= cfg_wdata;
          CFG_BAND_ABOVE: cfg_r.band_above <= cfg_wdata;
          CFG_MIN_WAIT:   cfg_r.min_wait   <= cfg_wdata[5:0];
          CFG_MIN_HEAT:   cfg_r.min_heat   <= cfg_wdata[5:0];
          CFG_IDLE_WAIT:  cfg_r.idle_wait  <= cfg_wdata;
          CFG_MAX_WAIT:   cfg_r.max_wait   <= cfg_wdata;
          default: begin
          end
        endcase
      end

      if (in_fire) st_r <= st_nxt;

      if (out_free) begin
        // The skid entry is older than any beat taken now, so it goes first.
        if (skid_valid_r) begin
          out_r        <= skid_r;
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else if (in_fire) begin
          out_r       <= res;
          out_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b0;
        end
      end else if (in_fire) begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end
  end

endmodule

// File: design/aht_checker.sv
module aht_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // A result beat that is not taken stays and holds its data.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("out_ beat dropped or changed while stalled");

  // The heater never runs without the fan.
  a_heater_fan: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && !out_tdata[1]))
    else $error("heater_on without fan_on");

  // An accepted beat always has a result waiting in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted beat produced no result");

  // Back-pressure on in_ only comes from a full output buffer.
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("in_tready low with empty output");

  // Reset empties the output buffer.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high right after reset");

endmodule

bind adaptive_heater_thermostat aht_checker u_aht_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
